FILE: src/time_triggered_task_scheduler_assert.svh
// Assertion macros used by the scheduler checker.
`ifndef TIME_TRIGGERED_TASK_SCHEDULER_ASSERT_SVH
`define TIME_TRIGGERED_TASK_SCHEDULER_ASSERT_SVH

// Same-cycle implication, skipped while reset is asserted.
`define TTS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("scheduler assertion failed");

// Next-cycle implication, skipped while reset is asserted.
`define TTS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("scheduler assertion failed");

`endif

FILE: src/tts_pkg.sv
// Shared types and constants for the time-triggered task scheduler.
package tts_pkg;

    localparam int MAX_TASKS = 8;
    localparam int IDX_W     = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
    localparam int CNT_W     = IDX_W + 1;
    localparam int SLOT_W    = 4;
    localparam int IN_W      = 48;
    localparam int OUT_W     = 16;

    typedef enum logic [1:0] {
        MODE_TICK     = 2'd0,
        MODE_ADD      = 2'd1,
        MODE_DELETE   = 2'd2,
        MODE_DISPATCH = 2'd3
    } t_mode;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_WALK = 3'b010,
        S_RESP = 3'b100
    } t_state;

    typedef struct packed {
        logic [7:0]  tag;
        logic [15:0] delay;
        logic [15:0] period;
        logic [7:0]  due;
    } t_entry;

    typedef struct packed {
        t_entry entry;
        logic   emit;
    } t_upd_res;

    typedef struct packed {
        logic [2:0]  pad;
        logic [2:0]  slot_index;
        logic [15:0] repeat_period;
        logic [15:0] first_delay;
        logic [7:0]  task_tag;
        t_mode       mode;
    } t_in;

    typedef struct packed {
        logic [2:0]        pad;
        logic              ran;
        logic [7:0]        run_tag;
        logic [SLOT_W-1:0] slot;
    } t_out;

endpackage

FILE: src/tts_slot_ram.sv
// Slot table memory: one write port, one registered read port, reset-cleared valid bits.
module tts_slot_ram
    import tts_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_we,
    input  logic [IDX_W-1:0] i_waddr,
    input  t_entry           i_wdata,
    input  logic             i_re,
    input  logic [IDX_W-1:0] i_raddr,
    output t_entry           o_rdata
);

    t_entry               r_mem [MAX_TASKS];
    logic [MAX_TASKS-1:0] r_vld;
    t_entry               r_rdata;
    logic                 r_rvld;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld  <= '0;
            r_rvld <= 1'b0;
        end else begin
            if (i_we) begin
                r_vld[i_waddr] <= 1'b1;
            end
            if (i_re) begin
                r_rvld <= r_vld[i_raddr];
            end
        end
    end

    // unwritten entries read as the cleared slot
    assign o_rdata = r_rvld ? r_rdata : '0;

endmodule

FILE: src/tts_slot_update.sv
// Per-slot read-modify step for tick and dispatch walks.
module tts_slot_update
    import tts_pkg::*;
(
    input  t_entry   i_cur,
    input  logic     i_tick,
    output t_upd_res o_res
);

    always_comb begin
        o_res.entry = i_cur;
        o_res.emit  = 1'b0;
        if (i_tick) begin
            if (i_cur.tag != 8'd0) begin
                if (i_cur.delay == 16'd0) begin
                    // saturate the due count, reload periodic slots
                    if (i_cur.due != 8'hFF) begin
                        o_res.entry.due = i_cur.due + 8'd1;
                    end
                    if (i_cur.period != 16'd0) begin
                        o_res.entry.delay = i_cur.period - 16'd1;
                    end
                end else begin
                    o_res.entry.delay = i_cur.delay - 16'd1;
                end
            end
        end else if (i_cur.tag != 8'd0 && i_cur.due != 8'd0) begin
            o_res.emit      = 1'b1;
            o_res.entry.due = i_cur.due - 8'd1;
            // drop one-shot slots once run
            if (i_cur.period == 16'd0) begin
                o_res.entry = '0;
            end
        end
    end

endmodule

FILE: src/time_triggered_task_scheduler.sv
// Top level of the time-triggered task scheduler: slot table, walk sequencer, output register.
// Add and nothing-due dispatch: accept moves to S_RESP, which loads one result item into the
// output register and returns to S_IDLE; delete: no result, the sequencer stays in S_IDLE.
// Tick and dispatch walk the slot memory one slot a cycle while the output side does not stall;
// a dispatched result that waits for the output register holds the walk.
// Synchronous active-low reset empties the table through the memory valid bits; tready is low.
module time_triggered_task_scheduler
    import tts_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    // tdata: mode[1:0], task_tag[9:2], first_delay[25:10], repeat_period[41:26],
    //        slot_index[44:42], zero pad[47:45]
    input  logic [IN_W-1:0]  i_s_axis_tdata,
    output logic             o_m_axis_tvalid,
    input  logic             i_m_axis_tready,
    // tdata: slot[3:0], run_tag[11:4], ran[12], zero pad[15:13]
    output logic [OUT_W-1:0] o_m_axis_tdata,
    output logic             o_m_axis_tlast
);

    // Sequencer state.
    t_state            r_state, n_state;
    logic              r_op_tick, n_op_tick;
    logic [CNT_W-1:0]  r_rd_idx, n_rd_idx;     // next slot to read
    logic              r_stg_vld, n_stg_vld;   // read data in flight for r_stg_idx
    logic [IDX_W-1:0]  r_stg_idx, n_stg_idx;
    logic [SLOT_W-1:0] r_resp_slot, n_resp_slot;

    // Per-slot summary bits, kept in step with every memory write.
    logic [MAX_TASKS-1:0] r_busy;   // tag is nonzero
    logic [MAX_TASKS-1:0] r_due;    // occupied and due count nonzero

    // Output register.
    logic r_out_vld, n_out_vld;
    t_out r_out, n_out;
    logic r_out_last, n_out_last;

    t_in              s_in;
    logic             s_accept;
    logic             s_out_busy;
    logic             s_advance;
    logic             s_re;
    logic             s_we;
    logic [IDX_W-1:0] s_waddr;
    t_entry           s_wdata;
    t_entry           s_rdata;
    t_upd_res         s_upd;
    logic             s_free_found;
    logic [IDX_W-1:0] s_free_idx;
    logic [MAX_TASKS-1:0] s_above;
    logic             s_later_due;

    assign s_in            = t_in'(i_s_axis_tdata);
    assign o_s_axis_tready = (r_state == S_IDLE) && i_rst_n;
    assign s_accept        = i_s_axis_tvalid && o_s_axis_tready;

    // The output register cannot take a new item this cycle.
    assign s_out_busy = r_out_vld && !i_m_axis_tready;

    // Hold the walk while a dispatched item waits for the output register.
    assign s_advance = !(r_stg_vld && s_upd.emit && s_out_busy);

    assign s_re = (r_state == S_WALK) && s_advance && (r_rd_idx != CNT_W'(MAX_TASKS));

    tts_slot_ram u_ram (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (s_we),
        .i_waddr (s_waddr),
        .i_wdata (s_wdata),
        .i_re    (s_re),
        .i_raddr (r_rd_idx[IDX_W-1:0]),
        .o_rdata (s_rdata)
    );

    tts_slot_update u_upd (
        .i_cur  (s_rdata),
        .i_tick (r_op_tick),
        .o_res  (s_upd)
    );

    // First free slot, lowest index wins.
    always_comb begin
        s_free_found = 1'b0;
        s_free_idx   = '0;
        for (int j = MAX_TASKS - 1; j >= 0; j--) begin
            if (!r_busy[j]) begin
                s_free_found = 1'b1;
                s_free_idx   = IDX_W'(j);
            end
        end
    end

    // A dispatched item is the last one when no higher slot is still due.
    always_comb begin
        for (int j = 0; j < MAX_TASKS; j++) begin
            s_above[j] = (IDX_W'(j) > r_stg_idx);
        end
    end
    assign s_later_due = |(r_due & s_above);

    // Memory write port: walk write-back, or a direct add or delete on accept.
    always_comb begin
        s_we    = 1'b0;
        s_waddr = r_stg_idx;
        s_wdata = s_upd.entry;
        if (r_state == S_WALK) begin
            s_we = r_stg_vld && s_advance;
        end else if (s_accept) begin
            case (s_in.mode)
                MODE_ADD: begin
                    s_we          = s_free_found;
                    s_waddr       = s_free_idx;
                    s_wdata.tag    = s_in.task_tag;
                    s_wdata.delay  = s_in.first_delay;
                    s_wdata.period = s_in.repeat_period;
                    s_wdata.due    = 8'd0;
                end
                MODE_DELETE: begin
                    s_we    = (int'(s_in.slot_index) < MAX_TASKS);
                    s_waddr = IDX_W'(s_in.slot_index);
                    s_wdata = '0;
                end
                default: begin
                    s_we = 1'b0;
                end
            endcase
        end
    end

    // Sequencer and output register next state.
    always_comb begin
        n_state     = r_state;
        n_op_tick   = r_op_tick;
        n_rd_idx    = r_rd_idx;
        n_stg_vld   = r_stg_vld;
        n_stg_idx   = r_stg_idx;
        n_resp_slot = r_resp_slot;
        n_out_vld   = r_out_vld && !i_m_axis_tready;
        n_out       = r_out;
        n_out_last  = r_out_last;

        case (r_state)
            S_IDLE: begin
                if (s_accept) begin
                    case (s_in.mode)
                        MODE_TICK: begin
                            n_state   = S_WALK;
                            n_op_tick = 1'b1;
                            n_rd_idx  = '0;
                        end
                        MODE_ADD: begin
                            n_state     = S_RESP;
                            n_resp_slot = s_free_found ? SLOT_W'(s_free_idx)
                                                       : SLOT_W'(MAX_TASKS);
                        end
                        MODE_DISPATCH: begin
                            if (|r_due) begin
                                n_state   = S_WALK;
                                n_op_tick = 1'b0;
                                n_rd_idx  = '0;
                            end else begin
                                // nothing due: answer with one idle item
                                n_state     = S_RESP;
                                n_resp_slot = SLOT_W'(MAX_TASKS);
                            end
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            S_WALK: begin
                if (s_advance) begin
                    // emit the dispatched slot into the output register
                    if (r_stg_vld && s_upd.emit) begin
                        n_out_vld     = 1'b1;
                        n_out.pad     = '0;
                        n_out.ran     = 1'b1;
                        n_out.run_tag = s_rdata.tag;
                        n_out.slot    = SLOT_W'(r_stg_idx);
                        n_out_last    = !s_later_due;
                    end
                    n_stg_vld = s_re;
                    n_stg_idx = r_rd_idx[IDX_W-1:0];
                    if (s_re) begin
                        n_rd_idx = r_rd_idx + CNT_W'(1);
                    end
                    if (!r_stg_vld && !s_re) begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_RESP: begin
                if (!s_out_busy) begin
                    n_state       = S_IDLE;
                    n_out_vld     = 1'b1;
                    n_out.pad     = '0;
                    n_out.ran     = 1'b0;
                    n_out.run_tag = 8'd0;
                    n_out.slot    = r_resp_slot;
                    n_out_last    = 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_op_tick <= 1'b0;
            r_rd_idx  <= '0;
            r_stg_vld <= 1'b0;
            r_out_vld <= 1'b0;
            r_busy    <= '0;
            r_due     <= '0;
        end else begin
            r_state   <= n_state;
            r_op_tick <= n_op_tick;
            r_rd_idx  <= n_rd_idx;
            r_stg_vld <= n_stg_vld;
            r_out_vld <= n_out_vld;
            if (s_we) begin
                r_busy[s_waddr] <= (s_wdata.tag != 8'd0);
                r_due[s_waddr]  <= (s_wdata.tag != 8'd0) && (s_wdata.due != 8'd0);
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_stg_idx   <= n_stg_idx;
        r_resp_slot <= n_resp_slot;
        r_out       <= n_out;
        r_out_last  <= n_out_last;
    end

    assign o_m_axis_tvalid = r_out_vld;
    assign o_m_axis_tdata  = OUT_W'(r_out);
    assign o_m_axis_tlast  = r_out_last;

endmodule

FILE: src/tts_checker.sv
// Port-level checker for the scheduler, bound to the top level.
`include "time_triggered_task_scheduler_assert.svh"

module tts_checker
    import tts_pkg::*;
(
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             o_s_axis_tready,
    input logic             o_m_axis_tvalid,
    input logic             i_m_axis_tready,
    input logic [OUT_W-1:0] o_m_axis_tdata,
    input logic             o_m_axis_tlast
);

    logic [OUT_W:0]    s_payload;
    logic              s_stall;
    logic              s_ran;
    logic [7:0]        s_tag;
    logic [SLOT_W-1:0] s_slot;
    logic              s_plain;
    logic              s_run;
    logic              s_run_ok;

    assign s_payload = {o_m_axis_tlast, o_m_axis_tdata};
    assign s_stall   = o_m_axis_tvalid && !i_m_axis_tready;
    assign s_ran     = o_m_axis_tdata[12];
    assign s_tag     = o_m_axis_tdata[11:4];
    assign s_slot    = o_m_axis_tdata[3:0];
    assign s_plain   = o_m_axis_tvalid && !s_ran;
    assign s_run     = o_m_axis_tvalid && s_ran;
    assign s_run_ok  = (s_tag != 8'd0) && (s_slot < SLOT_W'(MAX_TASKS));

    // a stalled item holds its payload
    `TTS_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, s_stall, o_m_axis_tvalid && $stable(s_payload))

    // an add or idle item closes its input and names no task
    `TTS_ASSERT_IMP(a_plain_last, i_clk, i_rst_n, s_plain, o_m_axis_tlast && (s_tag == 8'd0))

    // a dispatched item names an occupied slot inside the table
    `TTS_ASSERT_IMP(a_ran_slot, i_clk, i_rst_n, s_run, s_run_ok)

    // no new input while a dispatch run is still open
    `TTS_ASSERT_IMP(a_run_busy, i_clk, i_rst_n, s_run && !o_m_axis_tlast, !o_s_axis_tready)

endmodule

bind time_triggered_task_scheduler tts_checker u_tts_checker (.*);
